@@ sv/mmss_pkg.sv @@
// Shared types, codes and lookup functions for the MM:SS clock block.
`timescale 1ns / 1ps

package mmss_pkg;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    // Special keys
    localparam logic [3:0] KEY_LEAVE_SET = 4'd14;
    localparam logic [3:0] KEY_ENTER_SET = 4'd15;

    // Entry positions, tens of minutes first
    localparam logic [1:0] POS_SEC_UNITS = 2'd0;
    localparam logic [1:0] POS_SEC_TENS  = 2'd1;
    localparam logic [1:0] POS_MIN_UNITS = 2'd2;
    localparam logic [1:0] POS_MIN_TENS  = 2'd3;

    // Digit limits
    localparam logic [3:0] TENS_LIMIT  = 4'd6;
    localparam logic [3:0] UNITS_LIMIT = 4'd10;

    // Drive defaults and config reset
    localparam logic [3:0]  DIGIT_OFF = 4'hf;
    localparam logic [7:0]  SEG_OFF   = 8'hff;
    localparam logic [1:0]  DOT_DIGIT = 2'd2;
    localparam logic [15:0] TPS_RESET = 16'd500;

    typedef struct packed {
        logic       kind;
        logic [3:0] key_code;
    } in_word_t;

    typedef struct packed {
        logic [3:0] digit_select;
        logic [7:0] segment_pattern;
        logic [3:0] sec_units;
        logic [2:0] sec_tens;
        logic [3:0] min_units;
        logic [2:0] min_tens;
        logic       setting_mode;
    } out_word_t;

    typedef struct packed {
        logic [2:0] min_tens;
        logic [3:0] min_units;
        logic [2:0] sec_tens;
        logic [3:0] sec_units;
    } time_digits_t;

    typedef struct packed {
        logic       take;
        logic       kind;
        logic [3:0] key_code;
    } item_ctl_t;

    // Active-low hex font, dot in bit 7 off
    function automatic logic [7:0] seg_font(input logic [3:0] value);
        logic [7:0] pat;
        begin
            case (value)
                4'h0:    pat = 8'hc0;
                4'h1:    pat = 8'hf9;
                4'h2:    pat = 8'ha4;
                4'h3:    pat = 8'hb0;
                4'h4:    pat = 8'h99;
                4'h5:    pat = 8'h92;
                4'h6:    pat = 8'h82;
                4'h7:    pat = 8'hf8;
                4'h8:    pat = 8'h80;
                4'h9:    pat = 8'h90;
                4'ha:    pat = 8'h88;
                4'hb:    pat = 8'h83;
                4'hc:    pat = 8'hc6;
                4'hd:    pat = 8'ha1;
                4'he:    pat = 8'h86;
                default: pat = 8'h8e;
            endcase
            return pat;
        end
    endfunction

    // Active-low one-cold digit enable
    function automatic logic [3:0] digit_enable(input logic [1:0] idx);
        logic [3:0] sel;
        begin
            case (idx)
                2'd0:    sel = 4'he;
                2'd1:    sel = 4'hd;
                2'd2:    sel = 4'hb;
                default: sel = 4'h7;
            endcase
            return sel;
        end
    endfunction

endpackage

@@ sv/mmss_time_core.sv @@
// Time keeping: prescaler, cascaded BCD counter and key entry of the digits.
`timescale 1ns / 1ps

module mmss_time_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mmss_pkg::item_ctl_t   ctl,
    input  logic [15:0]           ticks_per_second,
    output mmss_pkg::time_digits_t digits,
    output mmss_pkg::time_digits_t digits_next,
    output logic                  set_mode_next
);
    import mmss_pkg::*;

    time_digits_t digits_reg;
    logic [15:0]  prescale_reg;
    logic         set_mode_reg;
    logic [1:0]   entry_pos_reg;

    time_digits_t d_next;
    logic [15:0]  prescale_next;
    logic         set_mode_next_w;
    logic [1:0]   entry_pos_next;
    logic [15:0]  prescale_inc;
    logic [3:0]   su_inc;
    logic [2:0]   st_inc;
    logic [3:0]   mu_inc;
    logic [2:0]   mt_inc;
    logic         key_taken;
    logic         mode_on;

    always_comb
    begin
        d_next          = digits_reg;
        prescale_next   = prescale_reg;
        set_mode_next_w = set_mode_reg;
        entry_pos_next  = entry_pos_reg;
        prescale_inc    = prescale_reg + 16'd1;
        su_inc          = digits_reg.sec_units + 4'd1;
        st_inc          = digits_reg.sec_tens + 3'd1;
        mu_inc          = digits_reg.min_units + 4'd1;
        mt_inc          = digits_reg.min_tens + 3'd1;
        key_taken       = 1'b0;
        mode_on         = set_mode_reg || (ctl.key_code == KEY_ENTER_SET);

        if (ctl.kind == KIND_TICK)
        begin
            if (!set_mode_reg)
            begin
                prescale_next = prescale_inc;
                if (prescale_inc == ticks_per_second)
                begin
                    prescale_next = '0;
                    // Cascade the carry through the four digits
                    d_next.sec_units = su_inc;
                    if (su_inc >= UNITS_LIMIT)
                    begin
                        d_next.sec_units = '0;
                        d_next.sec_tens  = st_inc;
                        if ({1'b0, st_inc} >= TENS_LIMIT)
                        begin
                            d_next.sec_tens  = '0;
                            d_next.min_units = mu_inc;
                            if (mu_inc >= UNITS_LIMIT)
                            begin
                                d_next.min_units = '0;
                                d_next.min_tens  = mt_inc;
                                if ({1'b0, mt_inc} >= TENS_LIMIT)
                                begin
                                    d_next.min_tens = '0;
                                end
                            end
                        end
                    end
                end
            end
        end
        else if (mode_on)
        begin
            set_mode_next_w = 1'b1;
            case (entry_pos_reg)
                POS_MIN_TENS:
                begin
                    if (ctl.key_code < TENS_LIMIT)
                    begin
                        d_next.min_tens = ctl.key_code[2:0];
                        entry_pos_next  = POS_MIN_UNITS;
                        key_taken       = 1'b1;
                    end
                end
                POS_MIN_UNITS:
                begin
                    if (ctl.key_code < UNITS_LIMIT)
                    begin
                        d_next.min_units = ctl.key_code;
                        entry_pos_next   = POS_SEC_TENS;
                        key_taken        = 1'b1;
                    end
                end
                POS_SEC_TENS:
                begin
                    if (ctl.key_code < TENS_LIMIT)
                    begin
                        d_next.sec_tens = ctl.key_code[2:0];
                        entry_pos_next  = POS_SEC_UNITS;
                        key_taken       = 1'b1;
                    end
                end
                default:
                begin
                    if (ctl.key_code < UNITS_LIMIT)
                    begin
                        d_next.sec_units = ctl.key_code;
                        entry_pos_next   = POS_MIN_TENS;
                        key_taken        = 1'b1;
                    end
                end
            endcase
            if (!key_taken && ctl.key_code == KEY_LEAVE_SET)
            begin
                set_mode_next_w = 1'b0;
                entry_pos_next  = POS_MIN_TENS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg    <= '0;
            prescale_reg  <= '0;
            set_mode_reg  <= 1'b0;
            entry_pos_reg <= POS_MIN_TENS;
        end
        else if (ctl.take)
        begin
            digits_reg    <= d_next;
            prescale_reg  <= prescale_next;
            set_mode_reg  <= set_mode_next_w;
            entry_pos_reg <= entry_pos_next;
        end
    end

    assign digits        = digits_reg;
    assign digits_next   = d_next;
    assign set_mode_next = set_mode_next_w;

endmodule

@@ sv/mmss_clock_with_digit_entry_scan.sv @@
// Top level of the MM:SS clock with seven-segment scan and key entry.
`timescale 1ns / 1ps
// The result word is registered on the edge that accepts the input word.
// Throughput: one word per cycle; the output register frees as it is taken, so
// in_ready stays high while out_ready is high.
// Reset (rst_n, asynchronous, active low): time 00:00, prescaler 0, set mode off,
// entry at tens of minutes, scan pointer and limit 0, ticks_per_second 500.

module mmss_clock_with_digit_entry_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mmss_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mmss_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);
    import mmss_pkg::*;

    logic [15:0]  tps_reg;
    logic [1:0]   scan_ptr_reg;
    logic [1:0]   scan_lim_reg;
    logic         out_valid_reg;
    out_word_t    out_reg;

    logic         take;
    item_ctl_t    ctl;
    time_digits_t digits;
    time_digits_t digits_next;
    logic         set_mode_next;

    logic [1:0]   scan_lim_next;
    logic [2:0]   scan_step;
    logic [1:0]   scan_ptr_next;
    logic [3:0]   shown_digit;
    logic [3:0]   sel_w;
    logic [7:0]   pat_w;
    out_word_t    out_next;

    // Accept whenever the output register is empty or being drained this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign ctl.take     = take;
    assign ctl.kind     = in_data.kind;
    assign ctl.key_code = in_data.key_code;

    mmss_time_core u_time (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .ticks_per_second (tps_reg),
        .digits           (digits),
        .digits_next      (digits_next),
        .set_mode_next    (set_mode_next)
    );

    // Pick the digit under the scan pointer, using the time before this tick
    always_comb
    begin
        case (scan_ptr_reg)
            2'd0:    shown_digit = digits.sec_units;
            2'd1:    shown_digit = {1'b0, digits.sec_tens};
            2'd2:    shown_digit = digits.min_units;
            default: shown_digit = {1'b0, digits.min_tens};
        endcase
    end

    // Scan advance with leading-digit blanking; the limit holds between ticks
    always_comb
    begin
        scan_lim_next = scan_lim_reg;
        if (digits.sec_tens != '0)
        begin
            scan_lim_next = 2'd1;
        end
        if (digits.min_units != '0)
        begin
            scan_lim_next = 2'd2;
        end
        if (digits.min_tens != '0)
        begin
            scan_lim_next = 2'd3;
        end
        scan_step = {1'b0, scan_ptr_reg};
        // Minutes units alone lit among the upper digits: skip tens of seconds
        if (digits.min_tens == '0 && digits.min_units != '0 && digits.sec_tens == '0)
        begin
            scan_lim_next = 2'd2;
            scan_step     = scan_step + 3'd1;
        end
        scan_step = scan_step + 3'd1;
        if (scan_step > {1'b0, scan_lim_next})
        begin
            scan_step = '0;
        end
        scan_ptr_next = scan_step[1:0];
    end

    // Drive values: blank on key words, dot on the minutes units digit
    always_comb
    begin
        sel_w = DIGIT_OFF;
        pat_w = SEG_OFF;
        if (in_data.kind == KIND_TICK)
        begin
            sel_w = digit_enable(scan_ptr_reg);
            pat_w = seg_font(shown_digit);
            if (scan_ptr_reg == DOT_DIGIT)
            begin
                pat_w[7] = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next.digit_select    = sel_w;
        out_next.segment_pattern = pat_w;
        out_next.sec_units       = digits_next.sec_units;
        out_next.sec_tens        = digits_next.sec_tens;
        out_next.min_units       = digits_next.min_units;
        out_next.min_tens        = digits_next.min_tens;
        out_next.setting_mode    = set_mode_next;
    end

    // Config register and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg      <= TPS_RESET;
            scan_ptr_reg <= '0;
            scan_lim_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tps_reg <= cfg_wdata;
            end
            if (take && in_data.kind == KIND_TICK)
            begin
                scan_ptr_reg <= scan_ptr_next;
                scan_lim_reg <= scan_lim_next;
            end
        end
    end

    // Output register: load on accept, drop valid when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ dv/testbench.sv @@
// Testbench for the MM:SS clock: directed table and random key/tick words against a predictor.
`timescale 1ns / 1ps

module testbench;

    import mmss_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    // Cycles with no word moving on either side before the run is called dead.
    localparam int QUIET_LIMIT  = 2000;
    // Random words per segment; only words that tick or change state count.
    localparam int SEG_WORDS    = 250;
    localparam int SEG_COUNT    = 6;
    // Cycles to hold after the last result before the verdict.
    localparam int DRAIN_CYCLES = 4;

    // Prescaler setting per random segment; the extremes 1 and 65535 are in here.
    localparam logic [15:0] SEG_RATES [SEG_COUNT] =
        '{16'd1, 16'd65535, 16'd3, 16'd2, 16'd500, 16'd1};
    // Idle percentages per segment: receiver heavy, then swapped, then none.
    localparam int SEG_SEND_GAP [SEG_COUNT] = '{26, 26, 84, 84, 0, 0};
    localparam int SEG_RECV_GAP [SEG_COUNT] = '{84, 84, 26, 26, 0, 0};

    // Own copies of the drive tables.
    localparam logic [3:0] ONE_COLD [4] = '{4'he, 4'hd, 4'hb, 4'h7};
    localparam logic [7:0] HEX_FONT [16] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
    };

    // ------------------------------------------------------------------
    // Directed script
    // ------------------------------------------------------------------
    // One row is either a rate write or one input word. Where the result can be
    // read off by hand it is typed in; otherwise the predictor supplies it.
    typedef struct packed {
        logic        rate_row;
        logic [15:0] rate;
        in_word_t    word;
        logic        typed;
        out_word_t   shown;
    } script_row_t;

    localparam in_word_t  TICK      = {KIND_TICK, 4'd0};
    localparam in_word_t  NO_WORD   = '0;
    localparam out_word_t UNCHECKED = '0;
    localparam int        SCRIPT_LEN = 26;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // reset state: digit 0 shows a zero, prescaler at 500 does not fire
        {1'b0, 16'd0, TICK, 1'b1, {4'he, 8'hc0, 4'd0, 3'd0, 4'd0, 3'd0, 1'b0}},
        // digit and leave keys outside set mode are dropped
        {1'b0, 16'd0, {KIND_KEY, 4'd0}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd0, 3'd0, 1'b0}},
        {1'b0, 16'd0, {KIND_KEY, KEY_LEAVE_SET}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd0, 3'd0, 1'b0}},
        // prescaler fires every second tick from here on
        {1'b1, 16'd2, NO_WORD, 1'b0, UNCHECKED},
        // enter set mode, then each position with an out-of-range key first
        {1'b0, 16'd0, {KIND_KEY, KEY_ENTER_SET}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd0, 3'd0, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, 4'd6}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd0, 3'd0, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, 4'd5}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd0, 3'd5, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, 4'd10}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd0, 3'd5, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, 4'd9}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd9, 3'd5, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, 4'd6}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd0, 4'd9, 3'd5, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, 4'd5}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd5, 4'd9, 3'd5, 1'b1}},
        // enter key again while already setting: position kept
        {1'b0, 16'd0, {KIND_KEY, KEY_ENTER_SET}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd0, 3'd5, 4'd9, 3'd5, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, 4'd9}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd9, 3'd5, 4'd9, 3'd5, 1'b1}},
        // full scan of 59:59 while setting, dot on digit 2, time held
        {1'b0, 16'd0, TICK, 1'b1, {4'he, 8'h90, 4'd9, 3'd5, 4'd9, 3'd5, 1'b1}},
        {1'b0, 16'd0, TICK, 1'b1, {4'hd, 8'h92, 4'd9, 3'd5, 4'd9, 3'd5, 1'b1}},
        {1'b0, 16'd0, TICK, 1'b1, {4'hb, 8'h10, 4'd9, 3'd5, 4'd9, 3'd5, 1'b1}},
        {1'b0, 16'd0, TICK, 1'b1, {4'h7, 8'h92, 4'd9, 3'd5, 4'd9, 3'd5, 1'b1}},
        {1'b0, 16'd0, {KIND_KEY, KEY_LEAVE_SET}, 1'b1,
            {DIGIT_OFF, SEG_OFF, 4'd9, 3'd5, 4'd9, 3'd5, 1'b0}},
        // prescaler fires: 59:59 wraps to 00:00, old digit still on display
        {1'b0, 16'd0, TICK, 1'b1, {4'he, 8'h90, 4'd0, 3'd0, 4'd0, 3'd0, 1'b0}},
        // 03:00, leaving mid-entry, then the scan skips digit 1
        {1'b0, 16'd0, {KIND_KEY, KEY_ENTER_SET}, 1'b0, UNCHECKED},
        {1'b0, 16'd0, {KIND_KEY, 4'd0}, 1'b0, UNCHECKED},
        {1'b0, 16'd0, {KIND_KEY, 4'd3}, 1'b0, UNCHECKED},
        {1'b0, 16'd0, {KIND_KEY, KEY_LEAVE_SET}, 1'b0, UNCHECKED},
        {1'b0, 16'd0, TICK, 1'b0, UNCHECKED},
        {1'b0, 16'd0, TICK, 1'b0, UNCHECKED},
        {1'b0, 16'd0, TICK, 1'b0, UNCHECKED}
    };

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_word_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_data;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    mmss_clock_with_digit_entry_scan i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Clock predictor state
    // ------------------------------------------------------------------
    logic [15:0] tick_rate;
    logic [3:0]  sec_units_q;
    logic [2:0]  sec_tens_q;
    logic [3:0]  min_units_q;
    logic [2:0]  min_tens_q;
    logic [15:0] prescale_q;
    logic        setting_q;
    logic [1:0]  entry_pos_q;
    logic [1:0]  scan_ptr_q;
    logic [1:0]  scan_lim_q;
    // High when the last key word changed anything at all.
    logic        key_took;

    out_word_t   pending_q [$];
    int          failures = 0;
    int          send_gap = 0;
    int          recv_gap = 0;

    // Advance the predicted clock by one input word and return the result word.
    function automatic out_word_t clock_step(input in_word_t w);
        out_word_t  r;
        logic [1:0] p;
        logic [2:0] nxt;
        logic [3:0] digit;
        logic [7:0] pat;
        logic       taken;
        begin
            r.digit_select    = DIGIT_OFF;
            r.segment_pattern = SEG_OFF;
            key_took          = 1'b0;
            if (w.kind == KIND_TICK)
            begin
                // drive the digit under the pointer, as it stands before counting
                p = scan_ptr_q;
                case (p)
                    POS_SEC_UNITS: digit = sec_units_q;
                    POS_SEC_TENS:  digit = {1'b0, sec_tens_q};
                    POS_MIN_UNITS: digit = min_units_q;
                    default:       digit = {1'b0, min_tens_q};
                endcase
                pat = HEX_FONT[digit];
                if (p == DOT_DIGIT)
                    pat[7] = 1'b0;
                r.digit_select    = ONE_COLD[p];
                r.segment_pattern = pat;

                // limit from the highest nonzero upper digit, held while all three are zero
                if (sec_tens_q != 0)
                    scan_lim_q = 2'd1;
                if (min_units_q != 0)
                    scan_lim_q = 2'd2;
                if (min_tens_q != 0)
                    scan_lim_q = 2'd3;
                nxt = {1'b0, p};
                if (min_tens_q == 0 && min_units_q != 0 && sec_tens_q == 0)
                begin
                    scan_lim_q = 2'd2;
                    nxt = nxt + 3'd1;
                end
                nxt = nxt + 3'd1;
                if (nxt > {1'b0, scan_lim_q})
                    nxt = 3'd0;
                scan_ptr_q = nxt[1:0];

                if (!setting_q)
                begin
                    prescale_q = prescale_q + 16'd1;
                    if (prescale_q == tick_rate)
                    begin
                        prescale_q  = '0;
                        sec_units_q = sec_units_q + 4'd1;
                        if (sec_units_q >= UNITS_LIMIT)
                        begin
                            sec_units_q = '0;
                            sec_tens_q  = sec_tens_q + 3'd1;
                            if (sec_tens_q >= TENS_LIMIT)
                            begin
                                sec_tens_q  = '0;
                                min_units_q = min_units_q + 4'd1;
                                if (min_units_q >= UNITS_LIMIT)
                                begin
                                    min_units_q = '0;
                                    min_tens_q  = min_tens_q + 3'd1;
                                    if (min_tens_q >= TENS_LIMIT)
                                        min_tens_q = '0;
                                end
                            end
                        end
                    end
                end
            end
            else
            begin
                if (w.key_code == KEY_ENTER_SET)
                begin
                    key_took  = !setting_q;
                    setting_q = 1'b1;
                end
                if (setting_q)
                begin
                    taken = 1'b0;
                    case (entry_pos_q)
                        POS_MIN_TENS:
                            if (w.key_code < TENS_LIMIT)
                            begin
                                min_tens_q  = w.key_code[2:0];
                                entry_pos_q = POS_MIN_UNITS;
                                taken       = 1'b1;
                            end
                        POS_MIN_UNITS:
                            if (w.key_code < UNITS_LIMIT)
                            begin
                                min_units_q = w.key_code;
                                entry_pos_q = POS_SEC_TENS;
                                taken       = 1'b1;
                            end
                        POS_SEC_TENS:
                            if (w.key_code < TENS_LIMIT)
                            begin
                                sec_tens_q  = w.key_code[2:0];
                                entry_pos_q = POS_SEC_UNITS;
                                taken       = 1'b1;
                            end
                        default:
                            if (w.key_code < UNITS_LIMIT)
                            begin
                                sec_units_q = w.key_code;
                                entry_pos_q = POS_MIN_TENS;
                                taken       = 1'b1;
                            end
                    endcase
                    if (!taken && w.key_code == KEY_LEAVE_SET)
                    begin
                        setting_q   = 1'b0;
                        entry_pos_q = POS_MIN_TENS;
                        taken       = 1'b1;
                    end
                    key_took = key_took | taken;
                end
            end
            r.sec_units    = sec_units_q;
            r.sec_tens     = sec_tens_q;
            r.min_units    = min_units_q;
            r.min_tens     = min_tens_q;
            r.setting_mode = setting_q;
            return r;
        end
    endfunction

    // Pick the next random word. Mostly well-formed: ticks while running,
    // digit keys that fit the entry position while setting, with some noise.
    function automatic in_word_t pick_word();
        in_word_t w;
        int       roll;
        int       top;
        begin
            roll = $urandom_range(99);
            w    = {KIND_KEY, 4'($urandom_range(15))};
            if (setting_q)
            begin
                top = (entry_pos_q == POS_MIN_TENS || entry_pos_q == POS_SEC_TENS) ? 5 : 9;
                if (roll < 15)
                    w = TICK;
                else if (roll < 45)
                    w.key_code = 4'(top);           // favor the top digit to reach carries
                else if (roll < 72)
                    w.key_code = 4'($urandom_range(top));
                else if (roll < 84)
                    w.key_code = KEY_LEAVE_SET;
            end
            else
            begin
                if (roll < 85)
                    w = TICK;
                else if (roll < 93)
                    w.key_code = KEY_ENTER_SET;
            end
            return w;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------
    // Present one word, hold it until taken, then log what it should produce.
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t shown);
        out_word_t predicted;
        begin
            while ($urandom_range(99) < send_gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= w;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predicted = clock_step(w);
            pending_q.push_back(typed ? shown : predicted);
        end
    endtask

    // Write the rate register once every result is back; every word yields a
    // result, so an empty queue means the block is idle.
    task automatic load_rate(input logic [15:0] value);
        begin
            in_valid <= 1'b0;
            while (pending_q.size() != 0)
                @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we    <= 1'b0;
            tick_rate  = value;
        end
    endtask

    // Change the rate. A rate at or below the running count would stall the
    // seconds for a full 16-bit wrap, so first make the count match on one tick.
    task automatic set_rate(input logic [15:0] value);
        begin
            if (prescale_q >= value)
            begin
                if (setting_q)
                    send_word({KIND_KEY, KEY_LEAVE_SET}, 1'b0, UNCHECKED);
                load_rate(prescale_q + 16'd1);
                send_word(TICK, 1'b0, UNCHECKED);
            end
            load_rate(value);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, compare, watchdog
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        begin
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        end
    endfunction

    int quiet_cycles = 0;

    always @(posedge clk)
    begin : result_side
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result word with nothing expected: %h", out_data);
                failures++;
            end
            else
            begin
                want = pending_q.pop_front();
                check_field("digit_select", want.digit_select, out_data.digit_select);
                check_field("segment_pattern", want.segment_pattern,
                            out_data.segment_pattern);
                check_field("sec_units", want.sec_units, out_data.sec_units);
                check_field("sec_tens", want.sec_tens, out_data.sec_tens);
                check_field("min_units", want.min_units, out_data.min_units);
                check_field("min_tens", want.min_tens, out_data.min_tens);
                check_field("setting_mode", want.setting_mode, out_data.setting_mode);
            end
        end

        // count cycles in which no word moves on either side
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end

        out_ready <= ($urandom_range(99) >= recv_gap);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        in_word_t w;
        int       counted;

        // predictor comes up in the reset state
        tick_rate   = TPS_RESET;
        sec_units_q = '0;
        sec_tens_q  = '0;
        min_units_q = '0;
        min_tens_q  = '0;
        prescale_q  = '0;
        setting_q   = 1'b0;
        entry_pos_q = POS_MIN_TENS;
        scan_ptr_q  = '0;
        scan_lim_q  = '0;
        key_took    = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].rate_row)
                set_rate(SCRIPT[i].rate);
            else
                send_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].shown);
        end

        // random segments, each with its own rate and idling mix
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            set_rate(SEG_RATES[s]);
            send_gap = SEG_SEND_GAP[s];
            recv_gap = SEG_RECV_GAP[s];
            counted  = 0;
            while (counted < SEG_WORDS)
            begin
                w = pick_word();
                send_word(w, 1'b0, UNCHECKED);
                if (w.kind == KIND_TICK || key_took)
                    counted++;
            end
        end

        // drain: the watchdog bounds this wait
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
